### hdl/smbsw_pkg.sv
// smbsw_pkg: types and constants for the structure table walker
// used by the top level smbios_structure_walker; no dependencies

package smbsw_pkg;

   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [1:0] {
      CSR_TABLE_SIZE   = 2'd0,
      CSR_QUERY_TYPE   = 2'd1,
      CSR_QUERY_INDEX  = 2'd2,
      CSR_QUERY_HANDLE = 2'd3
   } csr_index_type;

   localparam logic [7:0]  END_TYPE          = 8'd127;
   localparam logic [7:0]  HEADER_BYTES      = 8'd4;
   localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
   localparam logic [15:0] TABLE_SIZE_RESET  = 16'hFFFF;
   localparam logic [15:0] QUERY_INDEX_RESET = 16'd1;

   typedef struct packed {
      logic [7:0]  struct_type;
      logic [15:0] struct_handle;
      logic [15:0] struct_offset;
      logic [15:0] struct_length;
      logic [15:0] type_ordinal;
      logic        type_hit;
      logic        handle_hit;
      logic        end_of_table;
      logic        overrun;
   } record_type;

endpackage

### hdl/smbsw_if.sv
// smbsw_if: valid/ready channel interfaces for table bytes and structure records
// standalone; no package dependency

interface smbsw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] table_byte;
   logic       first_of_table;

   modport source (output valid, output table_byte, output first_of_table, input ready);
   modport sink   (input valid, input table_byte, input first_of_table, output ready);
endinterface

interface smbsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  struct_type;
   logic [15:0] struct_handle;
   logic [15:0] struct_offset;
   logic [15:0] struct_length;
   logic [15:0] type_ordinal;
   logic        type_hit;
   logic        handle_hit;
   logic        end_of_table;
   logic        overrun;

   modport source (output valid, output struct_type, output struct_handle,
                   output struct_offset, output struct_length, output type_ordinal,
                   output type_hit, output handle_hit, output end_of_table,
                   output overrun, input ready);
   modport sink   (input valid, input struct_type, input struct_handle,
                   input struct_offset, input struct_length, input type_ordinal,
                   input type_hit, input handle_hit, input end_of_table,
                   input overrun, output ready);
endinterface

### hdl/smbios_structure_walker.sv
// smbios_structure_walker: walks a structure table one byte per transfer and
// emits one record per structure; depends on smbsw_pkg and smbsw_if
//
// Takes one table byte per clock cycle unless the input register holds. Each byte is
// captured in an input register; when that register advances, the walk state (offset,
// header fields, terminator search, type counter) is updated and a record for a
// finished structure lands in the result register, from which it is presented. Bytes
// keep flowing while a record waits; the input register holds only when its byte would
// produce a record and the result register is still occupied. A structure ends at the
// first double zero at or after its formatted length (at least 4), or early with overrun
// at offset >= table_size. After end of table or overrun, bytes are dropped until one
// marked first_of_table. Configuration is written through csr_we/csr_index/csr_data,
// by the user only while the walker is idle; the block itself does not enforce this.

module smbios_structure_walker
   import smbsw_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   smbsw_req_if.sink                req_chan,
   smbsw_rsp_if.source              rsp_chan
);

   localparam int CW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

   // configuration
   logic [15:0] table_size_ff;
   logic [7:0]  query_type_ff;
   logic [15:0] query_index_ff;
   logic [15:0] query_handle_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;

   // walk state
   logic [OFFSET_BITS-1:0] table_offset_ff, table_offset_in;
   logic [OFFSET_BITS-1:0] struct_start_ff, struct_start_in;
   logic [7:0]             formatted_length_ff, formatted_length_in;
   logic [7:0]             current_type_ff, current_type_in;
   logic [15:0]            current_handle_ff, current_handle_in;
   logic                   previous_zero_ff, previous_zero_in;
   logic [15:0]            type_count_ff, type_count_in;
   logic                   walk_done_ff, walk_done_in;

   // result register
   logic       rsp_valid_ff;
   record_type rsp_rec_ff, rec_in;

   // working values
   logic [OFFSET_BITS-1:0] s_offset, s_start, pos;
   logic [7:0]             s_flen, s_type, eff_len;
   logic [15:0]            s_handle, s_count;
   logic                   s_pz, s_done;
   logic                   ended, beyond, emit, is_q, eot;
   logic [CW-1:0]          start_w;
   logic [CW:0]            len_w;
   logic                   out_free, advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff   <= TABLE_SIZE_RESET;
         query_type_ff   <= '0;
         query_index_ff  <= QUERY_INDEX_RESET;
         query_handle_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_SIZE:   table_size_ff   <= csr_data;
            CSR_QUERY_TYPE:   query_type_ff   <= csr_data[7:0];
            CSR_QUERY_INDEX:  query_index_ff  <= csr_data;
            CSR_QUERY_HANDLE: query_handle_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      s_offset = in_first_ff ? '0 : table_offset_ff;
      s_start  = in_first_ff ? '0 : struct_start_ff;
      s_flen   = in_first_ff ? '0 : formatted_length_ff;
      s_type   = in_first_ff ? '0 : current_type_ff;
      s_handle = in_first_ff ? '0 : current_handle_ff;
      s_pz     = in_first_ff ? 1'b0 : previous_zero_ff;
      s_count  = in_first_ff ? '0 : type_count_ff;
      s_done   = in_first_ff ? 1'b0 : walk_done_ff;

      pos = s_offset - s_start;

      current_type_in     = s_type;
      current_handle_in   = s_handle;
      formatted_length_in = s_flen;
      previous_zero_in    = s_pz;

      // header capture
      if (pos == OFFSET_BITS'(0)) begin
         current_type_in     = in_byte_ff;
         current_handle_in   = '0;
         formatted_length_in = '0;
         previous_zero_in    = 1'b0;
      end else if (pos == OFFSET_BITS'(1)) begin
         formatted_length_in = in_byte_ff;
      end else if (pos == OFFSET_BITS'(2)) begin
         current_handle_in = {s_handle[15:8], in_byte_ff};
      end else if (pos == OFFSET_BITS'(3)) begin
         current_handle_in = {in_byte_ff, s_handle[7:0]};
      end

      eff_len = (formatted_length_in < HEADER_BYTES) ? HEADER_BYTES : formatted_length_in;

      // double zero search past the formatted area
      ended = 1'b0;
      if (pos >= OFFSET_BITS'(eff_len)) begin
         if (in_byte_ff == 8'd0 && previous_zero_in) begin
            ended = 1'b1;
         end else begin
            previous_zero_in = (in_byte_ff == 8'd0);
         end
      end

      beyond = (CW'(s_offset) >= CW'(table_size_ff)) || (s_offset == '1);
      emit   = !s_done && (ended || beyond);
      eot    = (current_type_in == END_TYPE);
      is_q   = (current_type_in == query_type_ff);

      type_count_in = s_count;
      if (emit && is_q && s_count != COUNT_MAX) begin
         type_count_in = s_count + 16'd1;
      end

      start_w = CW'(s_start);
      len_w   = (CW + 1)'(pos) + (CW + 1)'(1);

      rec_in.struct_type   = current_type_in;
      rec_in.struct_handle = current_handle_in;
      rec_in.struct_offset = start_w[15:0];
      rec_in.struct_length = len_w[15:0];
      rec_in.type_ordinal  = type_count_in;
      rec_in.type_hit      = is_q && (type_count_in == query_index_ff);
      rec_in.handle_hit    = (current_handle_in == query_handle_ff);
      rec_in.end_of_table  = eot;
      rec_in.overrun       = beyond;

      table_offset_in = s_offset + OFFSET_BITS'(1);
      struct_start_in = s_start;
      walk_done_in    = s_done;
      if (emit) begin
         if (eot || beyond) begin
            walk_done_in = 1'b1;
         end else begin
            struct_start_in  = s_offset + OFFSET_BITS'(1);
            previous_zero_in = 1'b0;
         end
      end

      // stopped walk: byte is dropped, state stays as it was
      if (s_done) begin
         table_offset_in     = s_offset;
         current_type_in     = s_type;
         current_handle_in   = s_handle;
         formatted_length_in = s_flen;
         previous_zero_in    = s_pz;
      end
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && (!emit || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.table_byte;
         in_first_ff <= req_chan.first_of_table;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_offset_ff     <= '0;
         struct_start_ff     <= '0;
         formatted_length_ff <= '0;
         current_type_ff     <= '0;
         current_handle_ff   <= '0;
         previous_zero_ff    <= 1'b0;
         type_count_ff       <= '0;
         walk_done_ff        <= 1'b0;
      end else if (advance) begin
         table_offset_ff     <= table_offset_in;
         struct_start_ff     <= struct_start_in;
         formatted_length_ff <= formatted_length_in;
         current_type_ff     <= current_type_in;
         current_handle_ff   <= current_handle_in;
         previous_zero_ff    <= previous_zero_in;
         type_count_ff       <= type_count_in;
         walk_done_ff        <= walk_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_rec_ff <= rec_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.struct_type   = rsp_rec_ff.struct_type;
   assign rsp_chan.struct_handle = rsp_rec_ff.struct_handle;
   assign rsp_chan.struct_offset = rsp_rec_ff.struct_offset;
   assign rsp_chan.struct_length = rsp_rec_ff.struct_length;
   assign rsp_chan.type_ordinal  = rsp_rec_ff.type_ordinal;
   assign rsp_chan.type_hit      = rsp_rec_ff.type_hit;
   assign rsp_chan.handle_hit    = rsp_rec_ff.handle_hit;
   assign rsp_chan.end_of_table  = rsp_rec_ff.end_of_table;
   assign rsp_chan.overrun       = rsp_rec_ff.overrun;

endmodule

### hdl/smbsw_checker.sv
// smbsw_checker: port-level assertions for smbios_structure_walker
// bound to the top level below; depends on smbsw_pkg

module smbsw_checker
   import smbsw_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  struct_type,
   input logic [15:0] struct_length,
   input logic [15:0] type_ordinal,
   input logic        type_hit,
   input logic        end_of_table
);

   // no record is presented right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("record valid after reset");

   // a stalled record transfer keeps its content
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(struct_type)
         && $stable(struct_length) && $stable(type_ordinal))
      else $error("stalled record changed");

   // end of table flag tracks the terminating structure type
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (end_of_table == (struct_type == END_TYPE)))
      else $error("end_of_table does not match type");

   // a type hit always carries a counted ordinal
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && type_hit |-> type_ordinal != 16'd0)
      else $error("type hit with zero ordinal");

endmodule

bind smbios_structure_walker smbsw_checker u_smbsw_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .struct_type   (rsp_chan.struct_type),
   .struct_length (rsp_chan.struct_length),
   .type_ordinal  (rsp_chan.type_ordinal),
   .type_hit      (rsp_chan.type_hit),
   .end_of_table  (rsp_chan.end_of_table)
);

### dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for smbios_structure_walker, streams structure tables byte by byte
// depends on smbsw_pkg and the smbsw_req_if / smbsw_rsp_if channel interfaces

module tb;
   import smbsw_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int WALK_BYTES = 1300;
   localparam int QUIET_TAIL = 200;
   localparam int SETTLE_CYCLES = 8;

   // mirrors the walk state and registers, queues the records the walker owes
   class walk_scoreboard;
      logic [15:0] table_size;
      logic [7:0]  query_type;
      logic [15:0] query_index;
      logic [15:0] query_handle;

      logic [15:0] offset;
      logic [15:0] start;
      logic [7:0]  flen;
      logic [7:0]  cur_type;
      logic [15:0] cur_handle;
      bit          prev_zero;
      logic [15:0] type_count;
      bit          done;

      record_type  owed_records[$];
      int          errors;
      int          live_bytes;

      function new();
         table_size = TABLE_SIZE_RESET;
         query_type = '0;
         query_index = QUERY_INDEX_RESET;
         query_handle = '0;
         errors = 0;
         live_bytes = 0;
         clear_walk();
      endfunction

      function void clear_walk();
         offset = '0;
         start = '0;
         flen = '0;
         cur_type = '0;
         cur_handle = '0;
         prev_zero = 1'b0;
         type_count = '0;
         done = 1'b0;
      endfunction

      function void set_config(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_TABLE_SIZE:   table_size = value;
            CSR_QUERY_TYPE:   query_type = value[7:0];
            CSR_QUERY_INDEX:  query_index = value;
            CSR_QUERY_HANDLE: query_handle = value;
            default: ;
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic first);
         logic [15:0] pos;
         logic [7:0]  eff;
         bit          ended;
         bit          beyond;
         bit          is_q;
         record_type  rec;
         live_bytes++;
         if (first)
            clear_walk();
         if (done)
            return;
         pos = offset - start;
         case (pos)
            16'd0: begin
               cur_type = b;
               cur_handle = '0;
               flen = '0;
               prev_zero = 1'b0;
            end
            16'd1: flen = b;
            16'd2: cur_handle[7:0] = b;
            16'd3: cur_handle[15:8] = b;
            default: ;
         endcase
         // terminator search never covers the header
         eff = (flen < HEADER_BYTES) ? HEADER_BYTES : flen;
         ended = 1'b0;
         if (pos >= eff) begin
            if (b == 8'd0 && prev_zero)
               ended = 1'b1;
            else
               prev_zero = (b == 8'd0);
         end
         beyond = (offset >= table_size) || (offset == 16'hFFFF);
         if (ended || beyond) begin
            is_q = (cur_type == query_type);
            if (is_q && type_count != COUNT_MAX)
               type_count++;
            rec.struct_type = cur_type;
            rec.struct_handle = cur_handle;
            rec.struct_offset = start;
            rec.struct_length = pos + 16'd1;
            rec.type_ordinal = type_count;
            rec.type_hit = is_q && (type_count == query_index);
            rec.handle_hit = (cur_handle == query_handle);
            rec.end_of_table = (cur_type == END_TYPE);
            rec.overrun = beyond;
            owed_records.push_back(rec);
            if (rec.end_of_table || beyond) begin
               done = 1'b1;
            end else begin
               start = offset + 16'd1;
               prev_zero = 1'b0;
            end
         end
         offset = offset + 16'd1;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_field(string name, int unsigned got, int unsigned want);
         if (got != want)
            report_mismatch($sformatf("%s got 'h%0h expected 'h%0h", name, got, want));
      endtask

      task check_record(record_type got);
         record_type want;
         if (owed_records.size() == 0) begin
            report_mismatch($sformatf("unexpected record type 'h%0h offset 'h%0h",
                                      got.struct_type, got.struct_offset));
            return;
         end
         want = owed_records.pop_front();
         check_field("struct_type", got.struct_type, want.struct_type);
         check_field("struct_handle", got.struct_handle, want.struct_handle);
         check_field("struct_offset", got.struct_offset, want.struct_offset);
         check_field("struct_length", got.struct_length, want.struct_length);
         check_field("type_ordinal", got.type_ordinal, want.type_ordinal);
         check_field("type_hit", got.type_hit, want.type_hit);
         check_field("handle_hit", got.handle_hit, want.handle_hit);
         check_field("end_of_table", got.end_of_table, want.end_of_table);
         check_field("overrun", got.overrun, want.overrun);
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   smbsw_req_if req_chan();
   smbsw_rsp_if rsp_chan();

   walk_scoreboard sb;
   bit             idle_on;
   int             cycle_count;
   logic [7:0]     table_bytes[$];

   smbios_structure_walker dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_record({rsp_chan.struct_type, rsp_chan.struct_handle,
                          rsp_chan.struct_offset, rsp_chan.struct_length,
                          rsp_chan.type_ordinal, rsp_chan.type_hit, rsp_chan.handle_hit,
                          rsp_chan.end_of_table, rsp_chan.overrun});
   end

   // result side back-pressure in random bursts while idle_on is set
   initial begin : rsp_stall
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 12);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic first);
      int gap;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.table_byte <= b;
      req_chan.first_of_table <= first;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sb.note_byte(b, first);
   endtask

   task automatic send_table(int count);
      for (int i = 0; i < count; i++)
         send_byte(table_bytes[i], i == 0);
   endtask

   // pause the sender until every owed record is out and the pipeline is empty
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.owed_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      sb.set_config(idx, value);
   endtask

   task automatic write_config(logic [15:0] size, logic [7:0] qtype, logic [15:0] qidx,
                               logic [15:0] qhandle);
      put_csr(CSR_TABLE_SIZE, size);
      put_csr(CSR_QUERY_TYPE, {8'd0, qtype});
      put_csr(CSR_QUERY_INDEX, qidx);
      put_csr(CSR_QUERY_HANDLE, qhandle);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 4))
         0, 1:    return sb.query_type;
         2:       return 8'($urandom_range(0, 4));
         default: return 8'($urandom);
      endcase
   endfunction

   // header, formatted area, string set and the closing double zero
   function automatic void add_struct(logic [7:0] stype);
      int          flen;
      int          nstr;
      int          slen;
      logic [15:0] handle;
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
      case ($urandom_range(0, 3))
         0:       handle = sb.query_handle;
         1:       handle = 16'($urandom_range(0, 3));
         2:       handle = 16'hFFFF;
         default: handle = 16'($urandom);
      endcase
      table_bytes.push_back(stype);
      table_bytes.push_back(8'(flen));
      table_bytes.push_back(handle[7:0]);
      table_bytes.push_back(handle[15:8]);
      for (int i = 4; i < flen; i++)
         table_bytes.push_back(8'($urandom));
      nstr = $urandom_range(0, 2);
      for (int s = 0; s < nstr; s++) begin
         slen = $urandom_range(1, 6);
         for (int i = 0; i < slen; i++)
            table_bytes.push_back(8'($urandom_range(1, 255)));
         table_bytes.push_back(8'd0);
      end
      if (nstr == 0)
         table_bytes.push_back(8'd0);
      table_bytes.push_back(8'd0);
   endfunction

   initial begin : stimulus
      int          len;
      int          count;
      logic [15:0] size;
      logic [15:0] qidx;
      sb = new();
      idle_on = 1'b1;
      cycle_count = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TABLE_SIZE;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.table_byte = '0;
      req_chan.first_of_table = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: short formatted length, type and handle hit, end of table,
      // then a byte after the walk has stopped
      table_bytes = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h7F, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
      send_table(table_bytes.size());
      send_byte(8'hFF, 1'b0);
      drain();

      // empty table: overrun on the type byte, header unread, end of table and type hit
      write_config(16'd0, END_TYPE, 16'd1, 16'hFFFF);
      table_bytes = '{8'h7F};
      send_table(1);
      send_byte(8'h00, 1'b0);
      drain();

      // overrun on the first terminator byte, all-ones fields
      write_config(16'd5, 8'hFF, 16'hFFFF, 16'hABCD);
      table_bytes = '{8'hFF, 8'hFF, 8'hCD, 8'hAB, 8'h55, 8'h00};
      send_table(table_bytes.size());
      drain();

      while (sb.live_bytes < WALK_BYTES) begin
         idle_on = (sb.live_bytes < WALK_BYTES - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         table_bytes.delete();
         if ($urandom_range(0, 9) == 0) begin
            // noise with scattered table starts
            len = $urandom_range(5, 30);
            for (int i = 0; i < len; i++)
               send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            continue;
         end
         repeat ($urandom_range(1, 6)) add_struct(pick_type());
         if ($urandom_range(0, 9) != 0)
            add_struct(END_TYPE);
         len = table_bytes.size();
         if ($urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: size = 16'(len);
               5, 6:          size = 16'($urandom_range(0, len - 1));
               7:             size = 16'hFFFF;
               default:       size = 16'(len + $urandom_range(0, 40));
            endcase
            case ($urandom_range(0, 9))
               0:       qidx = 16'hFFFF;
               1:       qidx = 16'($urandom_range(1, 65535));
               default: qidx = 16'($urandom_range(1, 4));
            endcase
            drain();
            write_config(size,
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
                         qidx,
                         ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom));
         end
         // broken tables: cut off mid structure, the next start clears the walk
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
         send_table(count);
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end

      drain();
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
